// File: sv/lfta_pkg.sv
// shared types and constants for the lowest free unit timed allocator
// no dependencies; imported by lfta_scan and the top level
package lfta_pkg;

  localparam int TAG_W = 16;
  localparam int UNIT_W = 5;
  localparam int CFG_W = 5;
  localparam logic [CFG_W-1:0] NUM_TAXIS_RESET = 5'd16;

  localparam int OUT_BITS = TAG_W + 1 + UNIT_W;
  localparam int OUT_W = ((OUT_BITS + 7) / 8) * 8;
  localparam int OUT_PAD = OUT_W - OUT_BITS;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_TAIL,
    ST_COMMIT
  } state_t;

  typedef struct packed {
    logic init;
    logic cmp;
    logic commit;
  } scan_ctl_t;

endpackage

// File: sv/lfta_end_mem.sv
// end time store, one write port and one registered read port
// depends on nothing; used by the top level
module lfta_end_mem #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 33,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: sv/lfta_scan.sv
// busy bits, release compare and lowest free unit pick
// depends on lfta_pkg; used by the top level
module lfta_scan import lfta_pkg::*; #(
  parameter int MAX_UNITS = 16,
  parameter int TIME_WIDTH = 32,
  localparam int IDX_W = (MAX_UNITS > 1) ? $clog2(MAX_UNITS) : 1,
  localparam int ACT_W = (IDX_W + 1 > CFG_W) ? IDX_W + 1 : CFG_W
) (
  input  logic                  clk,
  input  logic                  rst,
  input  scan_ctl_t             ctl,
  input  logic [IDX_W-1:0]      cmp_idx,
  input  logic [TIME_WIDTH:0]   end_rdata,
  input  logic [TIME_WIDTH-1:0] start_time,
  input  logic [ACT_W-1:0]      active_lim,
  output logic                  found,
  output logic [IDX_W-1:0]      pick
);

  logic [MAX_UNITS-1:0] busy;
  logic                 release_hit;
  logic                 free_now;
  logic                 in_service;

  assign release_hit = busy[cmp_idx] && (end_rdata <= {1'b0, start_time});
  assign free_now    = !busy[cmp_idx] || release_hit;
  assign in_service  = ACT_W'(cmp_idx) < active_lim;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= '0;
    end else begin
      if (ctl.cmp && release_hit) begin
        busy[cmp_idx] <= 1'b0;
      end
      if (ctl.commit && found) begin
        busy[pick] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
    end else if (ctl.init) begin
      found <= 1'b0;
    end else if (ctl.cmp && !found && free_now && in_service) begin
      found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.cmp && !found && free_now && in_service) begin
      pick <= cmp_idx;
    end
  end

endmodule

// File: sv/lowest_free_unit_timed_allocator.sv
// lowest free unit timed allocator, top level with sequencer and stream ports
// depends on lfta_pkg, lfta_end_mem and lfta_scan
//
// Each request word carries a tag, a start time and a duration. The block walks
// the unit table one entry a cycle through a single end time comparator: busy
// units whose end time is at or before the start time are freed, and the lowest
// free unit below num_taxis is granted until start plus duration. The next request
// is accepted only once the last one is committed, since the one
// read port of the end time memory is walked once per request; the answer word
// (tag, granted, unit number, 0 when nothing was free) waits in an output
// register so the next request can be taken while it is pending. All units are
// free after reset; num_taxis resets to 16 and may only be written while idle.
module lowest_free_unit_timed_allocator import lfta_pkg::*; #(
  parameter int MAX_UNITS = 16,
  parameter int TIME_WIDTH = 32,
  localparam int IN_BITS = TAG_W + 2 * TIME_WIDTH,
  localparam int IN_W = ((IN_BITS + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_data,   // num_taxis
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [IN_W-1:0]  s_tdata,    // request_tag, start_time, duration
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata     // echo_tag, granted, unit_number
);

  localparam int IDX_W = (MAX_UNITS > 1) ? $clog2(MAX_UNITS) : 1;
  localparam int ACT_W = (IDX_W + 1 > CFG_W) ? IDX_W + 1 : CFG_W;
  localparam int END_W = TIME_WIDTH + 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_UNITS - 1);

  state_t state, state_next;

  logic [CFG_W-1:0]      num_taxis;
  logic [TAG_W-1:0]      req_tag;
  logic [TIME_WIDTH-1:0] start_time;
  logic [END_W-1:0]      end_time;
  logic [ACT_W-1:0]      active_lim;
  logic [IDX_W-1:0]      idx;
  logic [IDX_W-1:0]      cmp_idx;
  logic                  cmp_valid;
  logic [END_W-1:0]      end_rdata;
  logic                  found;
  logic [IDX_W-1:0]      pick;

  logic                  accept;
  logic                  issue;
  logic                  commit_go;
  scan_ctl_t             ctl;

  logic [TAG_W-1:0]      echo_tag;
  logic                  granted;
  logic [UNIT_W-1:0]     unit_number;

  logic [TIME_WIDTH-1:0] in_start;
  logic [TIME_WIDTH-1:0] in_dur;

  assign in_start = s_tdata[TAG_W +: TIME_WIDTH];
  assign in_dur   = s_tdata[TAG_W + TIME_WIDTH +: TIME_WIDTH];

  // config register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_taxis <= NUM_TAXIS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      num_taxis <= cfg_data;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (idx == LAST_IDX) state_next = ST_TAIL;
      end
      ST_TAIL: begin
        state_next = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (!m_tvalid || m_tready) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    s_tready  = 1'b0;
    issue     = 1'b0;
    commit_go = 1'b0;
    case (state)
      ST_IDLE:   s_tready  = 1'b1;
      ST_SCAN:   issue     = 1'b1;
      ST_COMMIT: commit_go = !m_tvalid || m_tready;
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

  assign accept     = s_tvalid && s_tready;
  assign ctl.init   = accept;
  assign ctl.cmp    = cmp_valid;
  assign ctl.commit = commit_go;

  // request capture
  always_ff @(posedge clk) begin
    if (accept) begin
      req_tag    <= s_tdata[TAG_W-1:0];
      start_time <= in_start;
      end_time   <= END_W'(in_start) + END_W'(in_dur);
      if (ACT_W'(num_taxis) > ACT_W'(MAX_UNITS)) begin
        active_lim <= ACT_W'(MAX_UNITS);
      end else begin
        active_lim <= ACT_W'(num_taxis);
      end
    end
  end

  // table walk address and compare stage
  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      cmp_valid <= 1'b0;
    end else begin
      cmp_valid <= issue;
      if (accept) begin
        idx <= '0;
      end else if (issue && idx != LAST_IDX) begin
        idx <= idx + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      cmp_idx <= idx;
    end
  end

  lfta_end_mem #(
    .DEPTH (MAX_UNITS),
    .WIDTH (END_W)
  ) u_end_mem (
    .clk   (clk),
    .we    (commit_go && found),
    .waddr (pick),
    .wdata (end_time),
    .re    (issue),
    .raddr (idx),
    .rdata (end_rdata)
  );

  lfta_scan #(
    .MAX_UNITS  (MAX_UNITS),
    .TIME_WIDTH (TIME_WIDTH)
  ) u_scan (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .cmp_idx    (cmp_idx),
    .end_rdata  (end_rdata),
    .start_time (start_time),
    .active_lim (active_lim),
    .found      (found),
    .pick       (pick)
  );

  // answer register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (commit_go) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit_go) begin
      echo_tag <= req_tag;
      granted  <= found;
      if (found) begin
        unit_number <= UNIT_W'(ACT_W'(pick) + ACT_W'(1));
      end else begin
        unit_number <= '0;
      end
    end
  end

  assign m_tdata = {{OUT_PAD{1'b0}}, unit_number, granted, echo_tag};

endmodule
